@@ sv/ptss_pkg.sv @@
// ----------------------------------------------------------------------------
// ptss_pkg: shared definitions for the priority task slot scheduler
// Slot state codes, command codes, register indexes and the table write bundle.
// ----------------------------------------------------------------------------
package ptss_pkg;

    // Default table depth
    localparam int SLOT_COUNT_DEF = 16;

    // Fixed field widths
    localparam int SLOT_FIELD_W = 4;
    localparam int PRIO_W       = 16;
    localparam int STATE_W      = 3;
    localparam int CMD_W        = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int SLOTS_W      = 4;

    // Reset value of slots_in_use
    localparam logic [SLOTS_W-1:0] SLOTS_IN_USE_RST = 4'd15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_PRIO    = 1'd1;

    // Slot state codes
    localparam logic [STATE_W-1:0] ST_UNUSED  = 3'd0;
    localparam logic [STATE_W-1:0] ST_FREE    = 3'd1;
    localparam logic [STATE_W-1:0] ST_ACTIVE  = 3'd2;
    localparam logic [STATE_W-1:0] ST_BLOCKED = 3'd3;
    localparam logic [STATE_W-1:0] ST_READY   = 3'd4;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_YIELD = 3'd0,
        CMD_BLOCK = 3'd1,
        CMD_KILL  = 3'd2,
        CMD_WAKE  = 3'd3,
        CMD_PUSH  = 3'd4,
        CMD_QUERY = 3'd5,
        CMD_FIND  = 3'd6
    } cmd_t;

    // Write controls for the slot table
    typedef struct packed {
        logic               st_we;
        logic [STATE_W-1:0] st_data;
        logic               pr_we;
        logic [PRIO_W-1:0]  pr_data;
    } tbl_wr_t;

endpackage

@@ sv/ptss_slot_table.sv @@
// ----------------------------------------------------------------------------
// ptss_slot_table: slot state and priority storage
// Two single-port-write, single-port-read memories with registered read data.
// Per-entry valid bits stand in for the reset values until an entry is written.
// ----------------------------------------------------------------------------
module ptss_slot_table #(
    parameter int SLOT_COUNT = ptss_pkg::SLOT_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ptss_pkg::tbl_wr_t                wr,
    input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] st_waddr,
    input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] pr_waddr,
    input  logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] rd_addr,
    output logic [ptss_pkg::STATE_W-1:0]     rd_state,
    output logic [ptss_pkg::PRIO_W-1:0]      rd_prio
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Storage
    logic [ptss_pkg::STATE_W-1:0] st_mem [SLOT_COUNT];
    logic [ptss_pkg::PRIO_W-1:0]  pr_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]        st_vld_reg;
    logic [SLOT_COUNT-1:0]        pr_vld_reg;

    // Read pipeline
    logic [ptss_pkg::STATE_W-1:0] st_rd_reg;
    logic [ptss_pkg::PRIO_W-1:0]  pr_rd_reg;
    logic                         st_rv_reg;
    logic                         pr_rv_reg;
    logic                         rz_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.st_we)
        begin
            st_mem[st_waddr] <= wr.st_data;
        end
        if (wr.pr_we)
        begin
            pr_mem[pr_waddr] <= wr.pr_data;
        end
        st_rd_reg <= st_mem[rd_addr];
        pr_rd_reg <= pr_mem[rd_addr];
        st_rv_reg <= st_vld_reg[rd_addr];
        pr_rv_reg <= pr_vld_reg[rd_addr];
        rz_reg    <= (rd_addr == SW'(0));
    end

    // Written-entry flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= '0;
            pr_vld_reg <= '0;
        end
        else
        begin
            if (wr.st_we)
            begin
                st_vld_reg[st_waddr] <= 1'b1;
            end
            if (wr.pr_we)
            begin
                pr_vld_reg[pr_waddr] <= 1'b1;
            end
        end
    end

    // Unwritten entries read as reset values: slot 0 active, others free
    assign rd_state = st_rv_reg ? st_rd_reg
                    : (rz_reg ? ptss_pkg::ST_ACTIVE : ptss_pkg::ST_FREE);
    assign rd_prio  = pr_rv_reg ? pr_rd_reg : '0;

endmodule

@@ sv/priority_task_slot_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// priority_task_slot_scheduler_top: rotating priority task slot scheduler
// Keeps a slot table and the active slot, and serves one command per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command request; output
//   channel (out_valid/out_stall) returns exactly one result per request.
//   in_stall is high while a request is being worked on or its result is
//   still waiting to enter the output register.
//   Yield, block, kill and query scan the other slots, one table read per
//   cycle; push and find free scan all slots. Wake and unknown commands go
//   straight to the finish step, which loads the result register. The next
//   request is accepted the cycle after the result register loads. The single
//   read port of the slot table sets the scan pace; one request is in flight
//   at a time. The user must write the configuration port (cfg_we/cfg_index/
//   cfg_data) only while the block is idle; the block does not enforce this.
//   Writing main_priority also loads slot 0's priority.
//   Reset (rst_n low, asynchronous) makes slot 0 active, all others free with
//   zero priority, slots_in_use 15 and main_priority 0; no clearing pass.
//   A stalled result stays in the output register; the next request is
//   accepted meanwhile and holds at its final step until the register frees.
// ----------------------------------------------------------------------------
module priority_task_slot_scheduler_top #(
    parameter int SLOT_COUNT = ptss_pkg::SLOT_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [ptss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptss_pkg::CFG_DATA_W-1:0]    cfg_data,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [ptss_pkg::CMD_W-1:0]         command,
    input  logic [ptss_pkg::SLOT_FIELD_W-1:0]  slot,
    input  logic                               slot_valid,
    input  logic [ptss_pkg::PRIO_W-1:0]        priority_req,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [ptss_pkg::SLOT_FIELD_W-1:0]  result_slot,
    output logic                               status,
    output logic [ptss_pkg::SLOT_FIELD_W-1:0]  previous_slot
);

    localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNTW = $clog2(SLOT_COUNT + 1);
    localparam int FW   = ptss_pkg::SLOT_FIELD_W;
    localparam int CW   = ((SW > FW) ? SW : FW) + 1;
    localparam int PW   = ptss_pkg::PRIO_W;
    localparam int STW  = ptss_pkg::STATE_W;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } fsm_t;

    fsm_t                           state_reg, state_next;
    logic [SW-1:0]                  active_reg, active_next;
    logic [ptss_pkg::SLOTS_W-1:0]   slots_reg;
    logic [ptss_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [PW-1:0]                  prio_in_reg, prio_in_next;
    logic [SW-1:0]                  prev_reg, prev_next;
    logic [SW-1:0]                  scan_idx_reg, scan_idx_next;
    logic [CNTW-1:0]                issue_cnt_reg, issue_cnt_next;
    logic                           rd_pend_reg, rd_pend_next;
    logic [SW-1:0]                  rd_idx_reg, rd_idx_next;
    logic [PW-1:0]                  best_reg, best_next;
    logic [SW-1:0]                  pick_reg, pick_next;
    logic                           found_reg, found_next;
    logic [SW-1:0]                  free_reg, free_next;
    logic [FW-1:0]                  res_reg, res_next;
    logic                           sts_reg, sts_next;
    logic                           out_valid_reg, out_valid_next;
    logic [FW-1:0]                  result_slot_reg, result_slot_next;
    logic                           status_reg, status_next;
    logic [FW-1:0]                  previous_slot_reg, previous_slot_next;

    // Table interface
    ptss_pkg::tbl_wr_t              tbl_wr;
    logic [SW-1:0]                  st_waddr;
    logic [SW-1:0]                  pr_waddr;
    logic [STW-1:0]                 rd_state;
    logic [PW-1:0]                  rd_prio;

    // Decode helpers
    logic                           cmd_select;
    logic                           cmd_leave;
    logic                           wake_ok;
    logic                           rd_in_use;
    logic [STW-1:0]                 rd_eff_state;
    logic [SW-1:0]                  active_plus1;

    ptss_slot_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .st_waddr (st_waddr),
        .pr_waddr (pr_waddr),
        .rd_addr  (scan_idx_reg),
        .rd_state (rd_state),
        .rd_prio  (rd_prio)
    );

    // Command classes
    assign cmd_leave  = (cmd_reg == ptss_pkg::CMD_YIELD) || (cmd_reg == ptss_pkg::CMD_BLOCK)
                     || (cmd_reg == ptss_pkg::CMD_KILL);
    assign cmd_select = cmd_leave || (cmd_reg == ptss_pkg::CMD_QUERY);

    // Wake handle check: valid, inside the table, and slot 0 or within slots_in_use
    assign wake_ok = slot_valid && (CW'(slot) < CW'(SLOT_COUNT))
                  && ((slot == '0) || (CW'(slot) <= CW'(slots_reg)));

    // Effective state of the slot whose data comes back from the table
    assign rd_in_use    = (rd_idx_reg == '0) || (CW'(rd_idx_reg) <= CW'(slots_reg));
    assign rd_eff_state = rd_in_use ? rd_state : ptss_pkg::ST_UNUSED;

    // Rotation start point
    assign active_plus1 = (active_reg == SW'(SLOT_COUNT - 1)) ? '0 : active_reg + SW'(1);

    // Sequencer and shared compare unit
    always_comb
    begin
        state_next         = state_reg;
        active_next        = active_reg;
        cmd_next           = cmd_reg;
        prio_in_next       = prio_in_reg;
        prev_next          = prev_reg;
        scan_idx_next      = scan_idx_reg;
        issue_cnt_next     = issue_cnt_reg;
        rd_pend_next       = 1'b0;
        rd_idx_next        = rd_idx_reg;
        best_next          = best_reg;
        pick_next          = pick_reg;
        found_next         = found_reg;
        free_next          = free_reg;
        res_next           = res_reg;
        sts_next           = sts_reg;
        out_valid_next     = out_valid_reg;
        result_slot_next   = result_slot_reg;
        status_next        = status_reg;
        previous_slot_next = previous_slot_reg;
        tbl_wr             = '0;
        st_waddr           = active_reg;
        pr_waddr           = '0;

        // result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // main priority register loads slot 0 priority
        if (cfg_we && (cfg_index == ptss_pkg::CFG_MAIN_PRIO))
        begin
            tbl_wr.pr_we   = 1'b1;
            tbl_wr.pr_data = cfg_data;
            pr_waddr       = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = command;
                    prio_in_next = priority_req;
                    prev_next    = active_reg;
                    best_next    = '0;
                    pick_next    = '0;
                    found_next   = 1'b0;
                    free_next    = '0;
                    case (command)
                        ptss_pkg::CMD_YIELD, ptss_pkg::CMD_BLOCK, ptss_pkg::CMD_KILL:
                        begin
                            // current slot leaves active before the scan
                            tbl_wr.st_we   = 1'b1;
                            st_waddr       = active_reg;
                            tbl_wr.st_data = (command == ptss_pkg::CMD_YIELD)
                                           ? ptss_pkg::ST_READY
                                           : ((command == ptss_pkg::CMD_BLOCK)
                                              ? ptss_pkg::ST_BLOCKED : ptss_pkg::ST_FREE);
                            scan_idx_next  = active_plus1;
                            issue_cnt_next = CNTW'(SLOT_COUNT - 1);
                            state_next     = S_SCAN;
                        end
                        ptss_pkg::CMD_QUERY:
                        begin
                            scan_idx_next  = active_plus1;
                            issue_cnt_next = CNTW'(SLOT_COUNT - 1);
                            state_next     = S_SCAN;
                        end
                        ptss_pkg::CMD_PUSH, ptss_pkg::CMD_FIND:
                        begin
                            scan_idx_next  = '0;
                            issue_cnt_next = CNTW'(SLOT_COUNT);
                            state_next     = S_SCAN;
                        end
                        ptss_pkg::CMD_WAKE:
                        begin
                            if (wake_ok)
                            begin
                                tbl_wr.st_we   = 1'b1;
                                st_waddr       = SW'(slot);
                                tbl_wr.st_data = ptss_pkg::ST_READY;
                            end
                            res_next   = slot;
                            sts_next   = !wake_ok;
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            res_next   = FW'(active_reg);
                            sts_next   = 1'b1;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // issue one table read per cycle
                if (issue_cnt_reg != '0)
                begin
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = scan_idx_reg;
                    scan_idx_next  = (scan_idx_reg == SW'(SLOT_COUNT - 1))
                                   ? '0 : scan_idx_reg + SW'(1);
                    issue_cnt_next = issue_cnt_reg - CNTW'(1);
                end

                // evaluate returned entry
                if (rd_pend_reg)
                begin
                    if (cmd_select)
                    begin
                        if ((rd_eff_state == ptss_pkg::ST_READY) && (rd_prio > best_reg))
                        begin
                            best_next = rd_prio;
                            pick_next = rd_idx_reg;
                        end
                    end
                    else if ((rd_eff_state == ptss_pkg::ST_FREE) && !found_reg)
                    begin
                        found_next = 1'b1;
                        free_next  = rd_idx_reg;
                    end
                end

                // scan complete: commit
                if ((issue_cnt_reg == '0) && !rd_pend_reg)
                begin
                    state_next = S_FINISH;
                    if (cmd_select)
                    begin
                        res_next = FW'(pick_reg);
                        sts_next = 1'b0;
                        if (cmd_leave)
                        begin
                            tbl_wr.st_we   = 1'b1;
                            st_waddr       = pick_reg;
                            tbl_wr.st_data = ptss_pkg::ST_ACTIVE;
                            active_next    = pick_reg;
                        end
                    end
                    else
                    begin
                        res_next = found_reg ? FW'(free_reg) : '0;
                        sts_next = !found_reg;
                        if (found_reg && (cmd_reg == ptss_pkg::CMD_PUSH))
                        begin
                            tbl_wr.st_we   = 1'b1;
                            st_waddr       = free_reg;
                            tbl_wr.st_data = ptss_pkg::ST_READY;
                            tbl_wr.pr_we   = 1'b1;
                            tbl_wr.pr_data = prio_in_reg;
                            pr_waddr       = free_reg;
                        end
                    end
                end
            end

            S_FINISH:
            begin
                // load output register when it is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    result_slot_next   = res_reg;
                    status_next        = sts_reg;
                    previous_slot_next = FW'(prev_reg);
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            slots_reg     <= ptss_pkg::SLOTS_IN_USE_RST;
            issue_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            best_reg      <= '0;
            pick_reg      <= '0;
            found_reg     <= 1'b0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            best_reg      <= best_next;
            pick_reg      <= pick_next;
            found_reg     <= found_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == ptss_pkg::CFG_SLOTS_IN_USE))
            begin
                slots_reg <= cfg_data[ptss_pkg::SLOTS_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        prio_in_reg       <= prio_in_next;
        prev_reg          <= prev_next;
        scan_idx_reg      <= scan_idx_next;
        rd_idx_reg        <= rd_idx_next;
        res_reg           <= res_next;
        sts_reg           <= sts_next;
        result_slot_reg   <= result_slot_next;
        status_reg        <= status_next;
        previous_slot_reg <= previous_slot_next;
    end

    // Ports
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign result_slot   = result_slot_reg;
    assign status        = status_reg;
    assign previous_slot = previous_slot_reg;

`ifndef NO_ASSERTIONS
    // A new result only appears from the finish step
    ap_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result register loaded outside finish step");

    // Active slot always lies inside the table
    ap_active_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(active_reg) < CW'(SLOT_COUNT))
        else $error("active slot out of range");

    // A nonzero pick needs a nonzero winning priority
    ap_pick_best: assert property (@(posedge clk) disable iff (!rst_n)
        (pick_reg != '0) |-> (best_reg != '0))
        else $error("slot picked without a positive priority");

    // No scan activity left over when a request may be accepted
    ap_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!rd_pend_reg && (issue_cnt_reg == '0)))
        else $error("scan still pending while idle");
`endif

endmodule
